FILE: rtl/stcm_pkg.sv
// Shared constants, codes and types of the sample-to-chunk offset mapper.
`timescale 1ns / 1ps
`default_nettype none

package stcm_pkg;

  // Table capacities.
  localparam int MAX_CHUNKS      = 1024;
  localparam int MAX_MAP_ENTRIES = 64;

  localparam int CHUNK_AW = $clog2(MAX_CHUNKS);
  localparam int MAP_AW   = $clog2(MAX_MAP_ENTRIES);

  // Field widths.
  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int SIZE_W    = 32;
  localparam int OFFSET_W  = 64;
  localparam int STATUS_W  = 2;
  localparam int CHUNK_CNT_W = 11;
  localparam int ENTRY_CNT_W = 7;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_MAP   = 2'd0,
    FUNC_LOAD_CHUNK = 2'd1,
    FUNC_MAP        = 2'd2,
    FUNC_RESTART    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_SIZE = 2'd0,
    REG_CHUNK_TOTAL  = 2'd1,
    REG_MAP_TOTAL    = 2'd2,
    REG_SAMPLE_TOTAL = 2'd3
  } reg_index_t;

endpackage

`default_nettype wire

FILE: rtl/stcm_if.sv
// Valid/ready channel interfaces for request and result words of the mapper.
`timescale 1ns / 1ps
`default_nettype none

interface stcm_in_if;
  import stcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [INDEX_W-1:0]  entry_index;
  logic [31:0]         start_chunk;
  logic [31:0]         samples_per_chunk;
  logic [OFFSET_W-1:0] chunk_offset;
  logic [SIZE_W-1:0]   sample_size;

  modport source (output valid, func, entry_index, start_chunk, samples_per_chunk,
                  chunk_offset, sample_size, input ready);
  modport sink (input valid, func, entry_index, start_chunk, samples_per_chunk,
                chunk_offset, sample_size, output ready);
endinterface

interface stcm_out_if;
  import stcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] sample_offset;
  logic [SIZE_W-1:0]   mapped_size;
  logic [SIZE_W-1:0]   largest_size;
  logic [STATUS_W-1:0] status;

  modport source (output valid, sample_offset, mapped_size, largest_size, status,
                  input ready);
  modport sink (input valid, sample_offset, mapped_size, largest_size, status,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/stcm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stcm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sample_to_chunk_offset_mapper_core.sv
// Top level of the sample-to-chunk offset mapper: sequencer, state registers and tables.
//
// Usage: request words arrive on req (valid/ready) and every request word gives exactly
// one result word on rsp (valid/ready). A request loads a sample-to-chunk entry, loads a
// chunk offset, maps one sample or restarts the running state. Registers are to be written
// through the APB-style port only while the block is idle; the block itself does not enforce
// this, the user must. pready is always high.
// A load, restart or rejected map word, and a map word that stays inside the current
// chunk, goes from the idle state straight to the emit state, where its result enters
// the output register once that is free; the block then returns to idle for the next word.
// A map word that opens a chunk walks the sample-to-chunk table held in a synchronous
// RAM with registered read data, through a read state and a check state per table entry
// visited, and the walk repeats for every chunk whose count turns out zero. Opening a
// chunk passes through the chunk, read, check and next states before the emit state.
// Only one word is in flight; the result sits in an output register, so the next
// request is accepted while a finished result still waits for the receiver. When the
// receiver stalls, a second finished result waits inside the block and no further
// request is taken until the output register frees up.
// Reset (rst, synchronous) clears the running state, the registers and the channels;
// table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sample_to_chunk_offset_mapper_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stcm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [stcm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [stcm_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  stcm_in_if.sink                            req,
  stcm_out_if.source                         rsp
);
  import stcm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHUNK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NEXT,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SIZE_W-1:0]      default_sample_size;
  logic [CHUNK_CNT_W-1:0] chunk_total;
  logic [ENTRY_CNT_W-1:0] map_entry_total;
  logic [31:0]            sample_total;

  // Running state.
  logic [CHUNK_CNT_W-1:0] current_chunk;
  logic [31:0]            samples_left;
  logic [OFFSET_W-1:0]    running_offset;
  logic [31:0]            samples_mapped;
  logic [SIZE_W-1:0]      largest_seen;

  // Work registers of the chunk search.
  logic [SIZE_W-1:0]      item_size;
  logic [ENTRY_CNT_W-1:0] scan_k;
  logic [31:0]            scan_count;

  // Result waiting for the output register, and the output register itself.
  logic [OFFSET_W-1:0] pend_offset;
  logic [SIZE_W-1:0]   pend_size;
  logic [SIZE_W-1:0]   pend_largest;
  status_t             pend_status;
  logic                out_valid;
  logic [OFFSET_W-1:0] out_offset;
  logic [SIZE_W-1:0]   out_size;
  logic [SIZE_W-1:0]   out_largest;
  status_t             out_status;

  logic                   req_fire;
  logic                   cfg_write;
  logic                   out_free;
  logic [CHUNK_CNT_W-1:0] chunks_lim;
  logic [ENTRY_CNT_W-1:0] entries_lim;
  logic [CHUNK_CNT_W-1:0] next_chunk;
  logic [SIZE_W-1:0]      size_sel;
  logic [SIZE_W-1:0]      cur_size;
  logic [SIZE_W-1:0]      largest_next;
  logic                   map_idx_ok;
  logic                   chunk_idx_ok;

  logic                 map_we;
  logic                 map_re;
  logic [63:0]          map_rdata;
  logic [31:0]          map_first;
  logic [31:0]          map_count;
  logic                 chunk_we;
  logic                 chunk_re;
  logic [OFFSET_W-1:0]  chunk_rdata;

  // ------------------------------------------------------------------
  // Configuration port. Registers are decoded on the word address.
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_sample_size <= '0;
      chunk_total         <= '0;
      map_entry_total     <= '0;
      sample_total        <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[3:2]))
        REG_DEFAULT_SIZE: default_sample_size <= pwdata;
        REG_CHUNK_TOTAL:  chunk_total         <= pwdata[CHUNK_CNT_W-1:0];
        REG_MAP_TOTAL:    map_entry_total     <= pwdata[ENTRY_CNT_W-1:0];
        REG_SAMPLE_TOTAL: sample_total        <= pwdata;
        default:          sample_total        <= sample_total;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_DEFAULT_SIZE: prdata = default_sample_size;
      REG_CHUNK_TOTAL:  prdata = PDATA_W'(chunk_total);
      REG_MAP_TOTAL:    prdata = PDATA_W'(map_entry_total);
      REG_SAMPLE_TOTAL: prdata = sample_total;
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Combinational helpers.
  // ------------------------------------------------------------------
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Totals above the table capacity are clipped to it.
  assign chunks_lim  = (chunk_total > CHUNK_CNT_W'(MAX_CHUNKS)) ?
                       CHUNK_CNT_W'(MAX_CHUNKS) : chunk_total;
  assign entries_lim = (map_entry_total > ENTRY_CNT_W'(MAX_MAP_ENTRIES)) ?
                       ENTRY_CNT_W'(MAX_MAP_ENTRIES) : map_entry_total;

  // 1-based number of the chunk being opened.
  assign next_chunk = current_chunk + CHUNK_CNT_W'(1);

  assign size_sel     = (default_sample_size != '0) ? default_sample_size : req.sample_size;
  assign cur_size     = (state == S_IDLE) ? size_sel : item_size;
  assign largest_next = (cur_size > largest_seen) ? cur_size : largest_seen;

  assign map_idx_ok   = ({1'b0, req.entry_index} < (INDEX_W + 1)'(MAX_MAP_ENTRIES));
  assign chunk_idx_ok = ({1'b0, req.entry_index} < (INDEX_W + 1)'(MAX_CHUNKS));

  // ------------------------------------------------------------------
  // Tables. Loads write only from the idle state and the search reads only
  // while a map word is in progress, so the ports never meet on one entry.
  // ------------------------------------------------------------------
  assign map_we = req_fire && (func_t'(req.func) == FUNC_LOAD_MAP) && map_idx_ok;
  assign map_re = (state == S_SCAN_RD) && (scan_k < entries_lim);
  assign map_first = map_rdata[63:32];
  assign map_count = map_rdata[31:0];

  stcm_ram #(
    .DEPTH (MAX_MAP_ENTRIES),
    .WIDTH (64)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (req.entry_index[MAP_AW-1:0]),
    .wdata ({req.start_chunk, req.samples_per_chunk}),
    .re    (map_re),
    .raddr (scan_k[MAP_AW-1:0]),
    .rdata (map_rdata)
  );

  assign chunk_we = req_fire && (func_t'(req.func) == FUNC_LOAD_CHUNK) && chunk_idx_ok;
  // The offset of the chunk about to be opened is fetched once, when its search
  // starts; the RAM holds the read data until the next read.
  assign chunk_re = (state == S_CHUNK) && (current_chunk < chunks_lim);

  stcm_ram #(
    .DEPTH (MAX_CHUNKS),
    .WIDTH (OFFSET_W)
  ) u_chunk_ram (
    .clk   (clk),
    .we    (chunk_we),
    .waddr (req.entry_index[CHUNK_AW-1:0]),
    .wdata (req.chunk_offset),
    .re    (chunk_re),
    .raddr (current_chunk[CHUNK_AW-1:0]),
    .rdata (chunk_rdata)
  );

  // ------------------------------------------------------------------
  // Sequencer, running state and output register.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      current_chunk  <= '0;
      samples_left   <= '0;
      running_offset <= '0;
      samples_mapped <= '0;
      largest_seen   <= '0;
    end else begin
      // The output register takes the pending result once it is free.
      if (state == S_EMIT && out_free) begin
        out_valid   <= 1'b1;
        out_offset  <= pend_offset;
        out_size    <= pend_size;
        out_largest <= pend_largest;
        out_status  <= pend_status;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            item_size    <= size_sel;
            pend_offset  <= '0;
            pend_size    <= '0;
            pend_largest <= largest_seen;
            pend_status  <= STAT_OK;
            state        <= S_EMIT;
            case (func_t'(req.func))
              FUNC_LOAD_MAP: begin
                if (!map_idx_ok) begin
                  pend_status <= STAT_RANGE;
                end
              end
              FUNC_LOAD_CHUNK: begin
                if (!chunk_idx_ok) begin
                  pend_status <= STAT_RANGE;
                end
              end
              FUNC_MAP: begin
                if (chunks_lim == '0 || entries_lim == '0) begin
                  pend_status <= STAT_EMPTY;
                end else if (samples_mapped >= sample_total) begin
                  pend_status <= STAT_RANGE;
                end else if (samples_left != '0) begin
                  // Still inside the current chunk: map right away.
                  pend_offset    <= running_offset;
                  pend_size      <= size_sel;
                  pend_largest   <= largest_next;
                  running_offset <= running_offset + OFFSET_W'(size_sel);
                  samples_left   <= samples_left - 32'd1;
                  samples_mapped <= samples_mapped + 32'd1;
                  largest_seen   <= largest_next;
                end else begin
                  state <= S_CHUNK;
                end
              end
              default: begin
                current_chunk  <= '0;
                samples_left   <= '0;
                running_offset <= '0;
                samples_mapped <= '0;
                largest_seen   <= '0;
                pend_largest   <= '0;
              end
            endcase
          end
        end

        S_CHUNK: begin
          if (current_chunk < chunks_lim) begin
            scan_k     <= '0;
            scan_count <= '0;
            state      <= S_SCAN_RD;
          end else begin
            // No chunk left; current_chunk stays at the total.
            pend_status <= STAT_EXHAUSTED;
            state       <= S_EMIT;
          end
        end

        S_SCAN_RD: begin
          if (scan_k < entries_lim) begin
            state <= S_SCAN_CHK;
          end else begin
            state <= S_NEXT;
          end
        end

        S_SCAN_CHK: begin
          // Later entries override earlier ones until one starts past this chunk.
          if (map_first <= 32'(next_chunk)) begin
            scan_count <= map_count;
            scan_k     <= scan_k + ENTRY_CNT_W'(1);
            state      <= S_SCAN_RD;
          end else begin
            state <= S_NEXT;
          end
        end

        S_NEXT: begin
          current_chunk <= next_chunk;
          if (scan_count != '0) begin
            pend_offset    <= chunk_rdata;
            pend_size      <= item_size;
            pend_largest   <= largest_next;
            running_offset <= chunk_rdata + OFFSET_W'(item_size);
            samples_left   <= scan_count - 32'd1;
            samples_mapped <= samples_mapped + 32'd1;
            largest_seen   <= largest_next;
            state          <= S_EMIT;
          end else begin
            // Empty chunk: move on to the next one.
            state <= S_CHUNK;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.sample_offset = out_offset;
  assign rsp.mapped_size   = out_size;
  assign rsp.largest_size  = out_largest;
  assign rsp.status        = out_status;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  // Only one word is in flight: an accepted word blocks the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another word is in progress");

  // A chunk search only starts once the current chunk is used up.
  a_search_empty_chunk: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHUNK || state == S_SCAN_RD || state == S_SCAN_CHK || state == S_NEXT)
    |-> (samples_left == '0))
    else $error("chunk search with samples left in the current chunk");

  // The table walk never reads past the loaded entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> (scan_k < entries_lim))
    else $error("table walk beyond the loaded entries");

  // Results other than a successful map carry no offset and no size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && out_status != STAT_OK) |-> (out_offset == '0 && out_size == '0))
    else $error("failed result carries an offset or size");

  // The chunk counter never passes the table capacity.
  a_chunk_bound: assert property (@(posedge clk) disable iff (rst)
    current_chunk <= CHUNK_CNT_W'(MAX_CHUNKS))
    else $error("chunk counter beyond the chunk table");

endmodule

`default_nettype wire

FILE: tb/sv/sample_to_chunk_offset_mapper_core_test.sv
// Self-checking testbench of the sample-to-chunk offset mapper core.
`timescale 1ns / 1ps

import stcm_pkg::*;

typedef struct {
  func_t                  func;
  bit [INDEX_W-1:0]       entry_index;
  bit [31:0]              start_chunk;
  bit [31:0]              samples_per_chunk;
  bit [OFFSET_W-1:0]      chunk_offset;
  bit [SIZE_W-1:0]        sample_size;
} request_word_t;

typedef struct {
  logic [OFFSET_W-1:0]    sample_offset;
  logic [SIZE_W-1:0]      mapped_size;
  logic [SIZE_W-1:0]      largest_size;
  logic [STATUS_W-1:0]    status;
} placement_t;

class offset_tracker;
  bit [31:0]            first_tbl [MAX_MAP_ENTRIES];
  bit [31:0]            count_tbl [MAX_MAP_ENTRIES];
  bit [OFFSET_W-1:0]    base_tbl [MAX_CHUNKS];
  bit                   map_loaded [MAX_MAP_ENTRIES];
  bit                   base_loaded [MAX_CHUNKS];

  bit [CHUNK_CNT_W-1:0] chunks_opened;
  bit [31:0]            left;
  bit [OFFSET_W-1:0]    cursor;
  bit [31:0]            mapped;
  bit [SIZE_W-1:0]      peak;

  bit [SIZE_W-1:0]      fixed_size;
  bit [CHUNK_CNT_W-1:0] chunk_limit;
  bit [ENTRY_CNT_W-1:0] entry_limit;
  bit [31:0]            track_len;

  placement_t           placements_due [$];
  int                   faults, results_checked, reg_writes;
  int                   maps_noted, loads_noted, restarts_noted;
  int                   status_tally [4];

  function void set_register(reg_index_t which, bit [31:0] value);
    case (which)
      REG_DEFAULT_SIZE: fixed_size = value;
      REG_CHUNK_TOTAL:  chunk_limit = value[CHUNK_CNT_W-1:0];
      REG_MAP_TOTAL:    entry_limit = value[ENTRY_CNT_W-1:0];
      default:          track_len = value;
    endcase
    reg_writes++;
  endfunction

  function int usable_chunks();
    return chunk_limit > MAX_CHUNKS ? MAX_CHUNKS : int'(chunk_limit);
  endfunction

  function int usable_entries();
    return entry_limit > MAX_MAP_ENTRIES ? MAX_MAP_ENTRIES : int'(entry_limit);
  endfunction

  // Count of the last entry whose first chunk does not lie beyond this chunk.
  function bit [31:0] per_chunk(bit [31:0] number, int entries);
    bit [31:0] spc;
    int k;
    spc = 0;
    for (k = 0; k < entries; k++) begin
      if (first_tbl[k] <= number) spc = count_tbl[k];
      else break;
    end
    return spc;
  endfunction

  function status_t place_sample(bit [SIZE_W-1:0] size, output bit [OFFSET_W-1:0] at);
    int chunks, entries;
    bit [31:0] spc;
    bit found;
    at = 0;
    chunks = usable_chunks();
    entries = usable_entries();
    if (chunks == 0 || entries == 0) return STAT_EMPTY;
    if (mapped >= track_len) return STAT_RANGE;
    if (left == 0) begin
      found = 1'b0;
      while (!found && chunks_opened < chunks) begin
        spc = per_chunk(32'(chunks_opened) + 32'd1, entries);
        chunks_opened++;
        if (spc != 0) begin
          cursor = base_tbl[chunks_opened - 1];
          left = spc;
          found = 1'b1;
        end
      end
      if (!found) return STAT_EXHAUSTED;
    end
    at = cursor;
    cursor += OFFSET_W'(size);
    left--;
    mapped++;
    if (size > peak) peak = size;
    return STAT_OK;
  endfunction

  // Walks what the next map word would read and names the first table entry
  // that has never been loaded, so that the stimulus can load it first.
  function bit first_gap(output bit in_base, output int slot);
    int chunks, entries, c, k;
    bit [31:0] spc;
    in_base = 1'b0;
    slot = 0;
    chunks = usable_chunks();
    entries = usable_entries();
    if (chunks == 0 || entries == 0 || mapped >= track_len || left != 0) return 1'b0;
    for (c = chunks_opened; c < chunks; c++) begin
      spc = 0;
      for (k = 0; k < entries; k++) begin
        if (!map_loaded[k]) begin
          slot = k;
          return 1'b1;
        end
        if (first_tbl[k] <= 32'(c + 1)) spc = count_tbl[k];
        else break;
      end
      if (spc != 0) begin
        if (base_loaded[c]) return 1'b0;
        in_base = 1'b1;
        slot = c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function void note_request(request_word_t w);
    placement_t p;
    bit [SIZE_W-1:0] size;
    bit [OFFSET_W-1:0] at;
    p.sample_offset = 0;
    p.mapped_size = 0;
    p.status = STAT_OK;
    case (w.func)
      FUNC_LOAD_MAP: begin
        loads_noted++;
        if (w.entry_index < MAX_MAP_ENTRIES) begin
          first_tbl[w.entry_index] = w.start_chunk;
          count_tbl[w.entry_index] = w.samples_per_chunk;
          map_loaded[w.entry_index] = 1'b1;
        end else begin
          p.status = STAT_RANGE;
        end
      end
      FUNC_LOAD_CHUNK: begin
        loads_noted++;
        if (w.entry_index < MAX_CHUNKS) begin
          base_tbl[w.entry_index] = w.chunk_offset;
          base_loaded[w.entry_index] = 1'b1;
        end else begin
          p.status = STAT_RANGE;
        end
      end
      FUNC_MAP: begin
        maps_noted++;
        size = fixed_size != 0 ? fixed_size : w.sample_size;
        p.status = place_sample(size, at);
        p.sample_offset = at;
        if (p.status == STAT_OK) p.mapped_size = size;
      end
      default: begin
        restarts_noted++;
        chunks_opened = 0;
        left = 0;
        cursor = 0;
        mapped = 0;
        peak = 0;
      end
    endcase
    p.largest_size = peak;
    status_tally[p.status]++;
    placements_due.push_back(p);
  endfunction

  function void report(string field, logic [63:0] want, logic [63:0] got);
    faults++;
    if (faults <= 10)
      $display("MISMATCH %0d on result %0d, %s: expected %h, got %h",
               faults, results_checked, field, want, got);
  endfunction

  function void check_placement(placement_t got);
    placement_t want;
    results_checked++;
    if (placements_due.size() == 0) begin
      report("result with nothing pending, status", 0, got.status);
      return;
    end
    want = placements_due.pop_front();
    if (got.sample_offset !== want.sample_offset)
      report("sample_offset", want.sample_offset, got.sample_offset);
    if (got.mapped_size !== want.mapped_size)
      report("mapped_size", want.mapped_size, got.mapped_size);
    if (got.largest_size !== want.largest_size)
      report("largest_size", want.largest_size, got.largest_size);
    if (got.status !== want.status)
      report("status", want.status, got.status);
  endfunction

  function void finish_up();
    if (placements_due.size() != 0) begin
      faults += placements_due.size();
      $display("%0d predicted results never arrived", placements_due.size());
    end
  endfunction
endclass

module sample_to_chunk_offset_mapper_core_test;

  // Idle cycles with no word moving on either channel before the run is
  // called hung. The limit must outlast the slowest single word, which walks
  // all 1024 chunks through a full 64-entry table.
  localparam int STALL_LIMIT   = 600000;
  // Cycles left to run once every expected word has come back; longer than
  // the opening of a chunk with a full table.
  localparam int SETTLE_CYCLES = 300;
  // Length of the receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 28;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  stcm_in_if  req_ch ();
  stcm_out_if rsp_ch ();

  offset_tracker tracker = new;

  // Idling odds in percent, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Asks the receiver for one long hold-off.
  bit hold_ask = 1'b0;

  sample_to_chunk_offset_mapper_core uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #1 clk = ~clk;

  // Every request field gets fresh random bits; callers then pin the fields
  // that matter for the word they build.
  function automatic request_word_t random_word(func_t f);
    request_word_t w;
    w.func = f;
    w.entry_index = INDEX_W'($urandom);
    w.start_chunk = $urandom;
    w.samples_per_chunk = $urandom;
    w.chunk_offset = {$urandom, $urandom};
    w.sample_size = $urandom;
    return w;
  endfunction

  // Offers one request word and returns at the edge where it is taken. The
  // valid line stays high afterwards so that a following word can go out
  // back to back; idling or drain() lowers it.
  task automatic send_word(request_word_t w);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.func              <= w.func;
    req_ch.entry_index       <= w.entry_index;
    req_ch.start_chunk       <= w.start_chunk;
    req_ch.samples_per_chunk <= w.samples_per_chunk;
    req_ch.chunk_offset      <= w.chunk_offset;
    req_ch.sample_size       <= w.sample_size;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    tracker.note_request(w);
  endtask

  task automatic load_entry(int slot, bit [31:0] first_no, bit [31:0] count);
    request_word_t w;
    w = random_word(FUNC_LOAD_MAP);
    w.entry_index = INDEX_W'(slot);
    w.start_chunk = first_no;
    w.samples_per_chunk = count;
    send_word(w);
  endtask

  task automatic load_base(int slot, bit [OFFSET_W-1:0] offset);
    request_word_t w;
    w = random_word(FUNC_LOAD_CHUNK);
    w.entry_index = INDEX_W'(slot);
    w.chunk_offset = offset;
    send_word(w);
  endtask

  // A map word never reads a table entry that was never loaded: any such
  // entry on its path is loaded first, map entries in ascending chunk order.
  task automatic send_map(bit [SIZE_W-1:0] size);
    request_word_t w;
    bit to_base;
    int slot;
    while (tracker.first_gap(to_base, slot)) begin
      if (to_base) begin
        load_base(slot, {$urandom, $urandom});
      end else begin
        load_entry(slot, slot == 0 ? 32'd1 : tracker.first_tbl[slot-1] + $urandom_range(3, 1),
                   $urandom_range(4, 1));
      end
    end
    w = random_word(FUNC_MAP);
    w.sample_size = size;
    send_word(w);
  endtask

  // APB write: setup phase, then access phase until pready, then psel and penable drop.
  task automatic write_reg(reg_index_t which, bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(which, value);
    @(posedge clk);
  endtask

  // Stops offering words and waits until every expected result has come
  // back. Each word gives exactly one result, so the block is idle then.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.placements_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks every word taken and decides ready for the next cycle.
  // One long hold-off is counted here while the sender keeps offering words.
  initial begin : receiver
    placement_t got;
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.sample_offset = rsp_ch.sample_offset;
        got.mapped_size   = rsp_ch.mapped_size;
        got.largest_size  = rsp_ch.largest_size;
        got.status        = rsp_ch.status;
        tracker.check_placement(got);
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_ask && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      rsp_ch.ready <= !rst && hold_left == 0 && $urandom_range(99, 0) >= recv_stall_pct;
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("No word moved for %0d cycles, giving up", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    request_word_t w;
    int phase, k, pick, chunks, entries;
    bit [31:0] fixed, track, first_no;

    req_ch.valid             <= 1'b0;
    req_ch.func              <= FUNC_LOAD_MAP;
    req_ch.entry_index       <= '0;
    req_ch.start_chunk       <= '0;
    req_ch.samples_per_chunk <= '0;
    req_ch.chunk_offset      <= '0;
    req_ch.sample_size       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Right after reset both table totals are zero, so a map
    // word reports empty tables and changes nothing.
    send_map(32'hFFFF_FFFF);
    // Chunk 1 holds two samples, chunk 2 none, chunk 3 one.
    load_entry(0, 32'd1, 32'd2);
    load_entry(1, 32'd2, 32'd0);
    load_entry(2, 32'd3, 32'd1);
    load_entry(MAX_MAP_ENTRIES - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Map entry indexes past the table are refused and write nothing.
    load_entry(MAX_MAP_ENTRIES, 32'd1, 32'd1);
    load_entry(1023, 32'd1, 32'd1);
    // The first chunk sits just below the top of the offset range, so the
    // second sample's offset wraps around to zero.
    load_base(0, 64'hFFFF_FFFF_FFFF_FFF0);
    load_base(2, 64'h0000_0001_0000_0000);
    load_base(1023, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(random_word(FUNC_RESTART));

    drain();
    write_reg(REG_DEFAULT_SIZE, 32'd0);
    write_reg(REG_CHUNK_TOTAL, 32'd3);
    write_reg(REG_MAP_TOTAL, 32'd3);
    write_reg(REG_SAMPLE_TOTAL, 32'd4);
    send_map(32'h10);
    send_map(32'h20);
    // Chunk 2 has a zero count and is stepped over on the way to chunk 3.
    send_map(32'h7);
    // No chunk left: the block says so now and on every map word until restart.
    send_map(32'h1);
    send_map(32'h2);
    send_word(random_word(FUNC_RESTART));

    // A fixed sample size of all ones, and a track one sample long: the
    // second map word runs past the declared sample count.
    drain();
    write_reg(REG_DEFAULT_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_SAMPLE_TOTAL, 32'd1);
    send_map(32'd0);
    send_map(32'd0);

    drain();
    write_reg(REG_DEFAULT_SIZE, 32'd0);
    write_reg(REG_CHUNK_TOTAL, MAX_CHUNKS);
    write_reg(REG_MAP_TOTAL, MAX_MAP_ENTRIES);
    write_reg(REG_SAMPLE_TOTAL, 32'd0);
    send_map(32'd9);

    drain();
    write_reg(REG_CHUNK_TOTAL, 32'd1);
    write_reg(REG_MAP_TOTAL, 32'd1);
    write_reg(REG_SAMPLE_TOTAL, 32'hFFFF_FFFF);
    send_word(random_word(FUNC_RESTART));
    send_map(32'd0);
    send_map(32'd5);
    send_map(32'd6);

    drain();
    write_reg(REG_CHUNK_TOTAL, 32'd0);
    write_reg(REG_MAP_TOTAL, 32'd0);
    send_map(32'd3);

    // Random part. Each phase sets the registers, restarts, loads a
    // well-formed sample-to-chunk table with random counts, then mostly maps
    // samples with some stray table loads and restarts mixed in.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          fixed = 0;
          chunks = MAX_CHUNKS;
          entries = MAX_MAP_ENTRIES;
          track = 32'hFFFF_FFFF;
        end
        1: begin
          fixed = 0;
          chunks = 1;
          entries = 1;
          track = $urandom_range(60, 0);
        end
        2: begin
          fixed = $urandom | 32'd1;
          chunks = $urandom_range(12, 1);
          entries = $urandom_range(8, 1);
          track = 32'hFFFF_FFFF;
        end
        3: begin
          fixed = 0;
          chunks = $urandom_range(20, 2);
          entries = $urandom_range(16, 1);
          track = $urandom_range(40, 10);
        end
        4: begin
          fixed = 32'hFFFF_FFFF;
          chunks = $urandom_range(30, 1);
          entries = $urandom_range(40, 17);
          track = 32'hFFFF_FFFF;
        end
        default: begin
          fixed = $urandom_range(1, 0) ? 32'd0 : $urandom;
          chunks = $urandom_range(32, 1);
          entries = $urandom_range(16, 1);
          track = $urandom_range(80, 1);
        end
      endcase

      drain();
      write_reg(REG_DEFAULT_SIZE, fixed);
      write_reg(REG_CHUNK_TOTAL, chunks);
      write_reg(REG_MAP_TOTAL, entries);
      write_reg(REG_SAMPLE_TOTAL, track);

      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      // In the first phase the receiver holds off while the table loads
      // stream in at full rate, so the block backs up and stalls its input.
      if (phase == 0) hold_ask = 1'b1;

      send_word(random_word(FUNC_RESTART));
      first_no = 1;
      for (k = 0; k < entries; k++) begin
        load_entry(k, first_no, $urandom_range(9, 0) == 0 ? 32'd0 : $urandom_range(4, 1));
        first_no += $urandom_range(3, 1);
      end

      repeat (PHASE_WORDS) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          send_map($urandom_range(1, 0) ? $urandom : $urandom_range(5000, 0));
        end else if (pick < 80) begin
          // Stray map entry: in or out of range, small or wild contents.
          w = random_word(FUNC_LOAD_MAP);
          w.entry_index = $urandom_range(1, 0) ? INDEX_W'($urandom_range(MAX_MAP_ENTRIES - 1, 0))
                                               : INDEX_W'($urandom_range(1023, MAX_MAP_ENTRIES));
          if ($urandom_range(1, 0)) begin
            w.start_chunk = $urandom_range(8, 0);
            w.samples_per_chunk = $urandom_range(5, 0);
          end
          send_word(w);
        end else if (pick < 90) begin
          send_word(random_word(FUNC_LOAD_CHUNK));
        end else begin
          send_word(random_word(FUNC_RESTART));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.finish_up();
    $display("Ran %0d map words, %0d table loads and %0d restarts under %0d register writes.",
             tracker.maps_noted, tracker.loads_noted, tracker.restarts_noted,
             tracker.reg_writes);
    $display("Results by status: ok %0d, chunks run out %0d, out of range %0d, empty %0d.",
             tracker.status_tally[STAT_OK], tracker.status_tally[STAT_EXHAUSTED],
             tracker.status_tally[STAT_RANGE], tracker.status_tally[STAT_EMPTY]);
    if (tracker.faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
